@@ rtl/ahdq_pkg.sv @@
// ----------------------------------------------------------------------------
// ahdq_pkg: shared types and constants of the half-rate dither quantizer
// Beat payload layouts, configuration register indexes and the limits of
// the 8-bit mono clip.
// ----------------------------------------------------------------------------
package ahdq_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MONO_W     = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int GAIN_W     = 8;
    localparam int ERR_W      = 12;

    // Mono clip limits.
    localparam int MONO_MIN = -128;
    localparam int MONO_MAX = 127;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 8'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd64;

    typedef enum logic {
        MODE_STEREO16 = 1'b0,
        MODE_MONO8    = 1'b1
    } t_mode;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_frame;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic signed [MONO_W-1:0]   mono_out;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg;

endpackage

@@ rtl/ahdq_ifs.sv @@
// ----------------------------------------------------------------------------
// ahdq_ifs: valid/ready channels of the half-rate dither quantizer
// Frame input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface ahdq_frame_if;
    logic            valid;
    logic            ready;
    ahdq_pkg::t_frame data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ahdq_result_if;
    logic             valid;
    logic             ready;
    ahdq_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ahdq_cfg_if;
    logic          valid;
    logic          ready;
    ahdq_pkg::t_cfg data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/audio_halfrate_dither_quantizer.sv @@
// ----------------------------------------------------------------------------
// audio_halfrate_dither_quantizer: 2:1 stereo decimator with 8-bit dither
// Filters stereo frames with a [1/4,1/2,1/4] kernel, emits one result for
// every pair of frames, and optionally folds it to a dithered 8-bit mono
// sample with error feedback.
// ----------------------------------------------------------------------------
//
//  Channel   | Dir | Payload                                  | Beat
//  ----------+-----+------------------------------------------+----------------
//  i_frame   | in  | left_sample, right_sample (s16)          | valid & ready
//  o_result  | out | left_out, right_out (s16), mono_out (s8) | valid & ready
//  i_cfg     | in  | index (u8), data (u8)                    | valid & ready
//
// One frame beat is accepted every cycle unless a stalled result backs up
// into the input register. A frame is registered in the input register,
// and its result is then registered in the result register, which drives
// result valid. Every odd frame produces a result; even frames only update
// filter state. A stalled result blocks the input register, which still
// holds one frame, so the input stops only when both registers are full.
// Reset (synchronous, active low) clears the filter and dither state, the
// frame phase and the configuration registers (16-bit mode, gain 64).
// ----------------------------------------------------------------------------
module audio_halfrate_dither_quantizer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ahdq_frame_if.sink           i_frame,
    ahdq_result_if.source        o_result,
    ahdq_cfg_if.sink             i_cfg
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; an index that
    // names no register is dropped.
    // ------------------------------------------------------------------
    ahdq_pkg::t_mode                   r_mode;
    logic [ahdq_pkg::GAIN_W-1:0]       r_gain;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ahdq_pkg::MODE_STEREO16;
            r_gain <= ahdq_pkg::GAIN_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.data.index == ahdq_pkg::CFG_OUTPUT_MODE) begin
                r_mode <= ahdq_pkg::t_mode'(i_cfg.data.data[0]);
            end
            if (i_cfg.data.index == ahdq_pkg::CFG_GAIN) begin
                r_gain <= i_cfg.data.data[ahdq_pkg::GAIN_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Input register. It advances whenever the result register can take
    // what this frame produces (or when it is empty).
    // ------------------------------------------------------------------
    logic                              r_in_valid;
    ahdq_pkg::t_frame                  r_in;
    logic                              r_out_valid;
    ahdq_pkg::t_result                 r_out;
    logic                              w_adv;
    logic                              w_proc;

    assign w_adv         = !r_out_valid || o_result.ready;
    assign w_proc        = r_in_valid && w_adv;
    assign i_frame.ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.valid && i_frame.ready) begin
            r_in <= i_frame.data;
        end
    end

    // ------------------------------------------------------------------
    // Filter state. The even frame contributes half its value on top of
    // the quarter tap kept from the previous odd frame; the odd frame then
    // adds its own quarter tap. All sums stay inside 16 bits.
    // ------------------------------------------------------------------
    logic                              r_phase;
    logic signed [15:0]                r_held_l;
    logic signed [15:0]                r_held_r;
    logic signed [13:0]                r_tap_l;
    logic signed [13:0]                r_tap_r;
    logic signed [ahdq_pkg::ERR_W-1:0] r_dither;

    logic signed [14:0] w_half_l;
    logic signed [14:0] w_half_r;
    logic signed [13:0] w_qtr_l;
    logic signed [13:0] w_qtr_r;
    logic signed [15:0] w_held_l;
    logic signed [15:0] w_held_r;
    logic signed [15:0] w_ol;
    logic signed [15:0] w_or;

    assign w_half_l = r_in.left_sample[15:1];
    assign w_half_r = r_in.right_sample[15:1];
    assign w_qtr_l  = r_in.left_sample[15:2];
    assign w_qtr_r  = r_in.right_sample[15:2];

    assign w_held_l = {{2{r_tap_l[13]}}, r_tap_l} + {w_half_l[14], w_half_l};
    assign w_held_r = {{2{r_tap_r[13]}}, r_tap_r} + {w_half_r[14], w_half_r};
    assign w_ol     = r_held_l + {{2{w_qtr_l[13]}}, w_qtr_l};
    assign w_or     = r_held_r + {{2{w_qtr_r[13]}}, w_qtr_r};

    // ------------------------------------------------------------------
    // Mono quantizer: scale the summed pair by gain/128, subtract the last
    // error, round on bit 7, truncate toward zero by 256 and clip. The new
    // error is taken from the unclipped quotient, so it stays well inside
    // twelve bits.
    // ------------------------------------------------------------------
    logic signed [16:0] w_sum;
    logic signed [25:0] w_prod;
    logic signed [18:0] w_scaled;
    logic signed [19:0] w_pre;
    logic signed [20:0] w_rnd;
    logic signed [20:0] w_bias;
    logic signed [12:0] w_q;
    logic signed [20:0] w_err;
    logic signed [7:0]  w_mono;

    assign w_sum    = {w_ol[15], w_ol} + {w_or[15], w_or};
    assign w_prod   = w_sum * $signed({1'b0, r_gain});
    assign w_scaled = w_prod[25:7];
    assign w_pre    = {w_scaled[18], w_scaled}
                    - {{(20 - ahdq_pkg::ERR_W){r_dither[ahdq_pkg::ERR_W-1]}}, r_dither};
    assign w_rnd    = {w_pre[19], w_pre} + {13'd0, w_pre[7], 7'd0};
    // Negative values are biased so that the shift truncates toward zero.
    assign w_bias   = w_rnd[20] ? (w_rnd + 21'sd255) : w_rnd;
    assign w_q      = w_bias[20:8];
    assign w_err    = {w_q, 8'd0} - {w_pre[19], w_pre};

    always_comb begin
        priority if (w_q < ahdq_pkg::MONO_MIN) begin
            w_mono = 8'(ahdq_pkg::MONO_MIN);
        end else if (w_q > ahdq_pkg::MONO_MAX) begin
            w_mono = 8'(ahdq_pkg::MONO_MAX);
        end else begin
            w_mono = w_q[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 1'b0;
            r_held_l <= '0;
            r_held_r <= '0;
            r_tap_l  <= '0;
            r_tap_r  <= '0;
            r_dither <= '0;
        end else if (w_proc) begin
            r_phase <= !r_phase;
            if (!r_phase) begin
                r_held_l <= w_held_l;
                r_held_r <= w_held_r;
            end else begin
                r_tap_l <= w_qtr_l;
                r_tap_r <= w_qtr_r;
                if (r_mode == ahdq_pkg::MODE_MONO8) begin
                    r_dither <= w_err[ahdq_pkg::ERR_W-1:0];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register. It loads on odd frames and empties on a taken beat.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_proc && r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_phase) begin
            r_out.left_out  <= w_ol;
            r_out.right_out <= w_or;
            r_out.mono_out  <= (r_mode == ahdq_pkg::MODE_MONO8) ? w_mono : 8'sd0;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

`ifndef ASSERT_OFF
    // An even frame only feeds the filter and never leaves a result behind.
    a_even_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && !r_phase) |=> !r_out_valid)
        else $error("even frame produced a result");

    // An odd frame always lands in the result register on the next edge.
    a_odd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_phase) |=> r_out_valid)
        else $error("odd frame lost its result");

    // In 16-bit mode the dither error is frozen.
    a_dither_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_phase && r_mode == ahdq_pkg::MODE_STEREO16) |=> $stable(r_dither))
        else $error("dither error moved in 16-bit mode");

    // The feedback error stays within its proven bounds.
    a_dither_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dither >= -12'sd255) && (r_dither <= 12'sd383))
        else $error("dither error out of range");

    // A full input register waiting on a stalled result is not overwritten.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in)))
        else $error("input register lost a stalled frame");
`endif

endmodule

@@ verif/audio_halfrate_dither_quantizer_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// audio_halfrate_dither_quantizer_tb: self-checking bench of the decimator
// Streams stereo frames through the block with random idle bursts on both
// channels. It predicts every decimated pair and dithered mono sample, and
// compares each result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module audio_halfrate_dither_quantizer_tb;

    localparam int CLK_HALF_NS  = 5;
    localparam int RESET_CYCLES = 12;
    // The block passes a frame through its input and result registers; allow a margin.
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 1050;
    localparam int QUIET_ITEMS   = 120;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 3_000_000;

    // An index that decodes to no register; writes to it must change nothing.
    localparam logic [ahdq_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 8'hA5;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ahdq_frame_if  frame_ch ();
    ahdq_result_if res_ch ();
    ahdq_cfg_if    cfg_ch ();

    audio_halfrate_dither_quantizer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // Frames waiting to be driven, and the results they are predicted to give.
    ahdq_pkg::t_frame  frame_q[$];
    ahdq_pkg::t_result expected_decim[$];

    // Copy of the configuration registers, updated on each config beat.
    ahdq_pkg::t_mode             cur_mode;
    logic [ahdq_pkg::GAIN_W-1:0] cur_gain;

    // Filter and dither state of the prediction.
    logic odd_frame;
    int   held_l, held_r;
    int   tap_l, tap_r;
    int   dith_err;

    // Idle control: percent chance of starting an idle burst, and burst counters.
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int src_gap;
    int snk_gap;

    int mismatch_cnt = 0;

    // Runs one accepted frame through the filter. An even frame only updates the
    // held partial sums; an odd frame completes the [1/4,1/2,1/4] kernel and, in
    // mono mode, also quantizes the pair with error feedback.
    function automatic void decimate_frame(input ahdq_pkg::t_frame f);
        int                l, r;
        int                amp, pre, q;
        ahdq_pkg::t_result res;
        l = $signed(f.left_sample);
        r = $signed(f.right_sample);
        if (!odd_frame) begin
            held_l = tap_l + (l >>> 1);
            held_r = tap_r + (r >>> 1);
            odd_frame = 1'b1;
        end else begin
            tap_l = l >>> 2;
            tap_r = r >>> 2;
            res.left_out  = 16'(held_l + tap_l);
            res.right_out = 16'(held_r + tap_r);
            res.mono_out  = '0;
            if (cur_mode == ahdq_pkg::MODE_MONO8) begin
                amp = ((held_l + tap_l + held_r + tap_r) * int'(cur_gain)) >>> 7;
                amp = amp - dith_err;
                pre = amp;
                // Round by adding bit 7 back in, then divide truncating toward zero.
                if (amp[7])
                    amp = amp + 128;
                q = amp / 256;
                // The error is taken before the clip, so it feeds back unclipped.
                dith_err = q * 256 - pre;
                if (q < ahdq_pkg::MONO_MIN)
                    q = ahdq_pkg::MONO_MIN;
                if (q > ahdq_pkg::MONO_MAX)
                    q = ahdq_pkg::MONO_MAX;
                res.mono_out = q[7:0];
            end
            odd_frame = 1'b0;
            expected_decim.push_back(res);
        end
    endfunction

    // Frame driver: predicts each accepted beat, then presents the next frame
    // unless an idle burst is running. Valid stays high until the beat is taken.
    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            frame_ch.valid <= 1'b0;
            src_gap <= 0;
            odd_frame = 1'b0;
            held_l = 0;
            held_r = 0;
            tap_l = 0;
            tap_r = 0;
            dith_err = 0;
        end else begin
            if (frame_ch.valid && frame_ch.ready)
                decimate_frame(frame_ch.data);
            if (!frame_ch.valid || frame_ch.ready) begin
                next_valid = 1'b0;
                if (src_gap != 0) begin
                    src_gap <= src_gap - 1;
                end else if (frame_q.size() != 0) begin
                    if (src_idle_pct != 0 && $urandom_range(1, 100) <= src_idle_pct) begin
                        src_gap <= $urandom_range(0, 6);
                    end else begin
                        next_valid = 1'b1;
                        frame_ch.data <= frame_q.pop_front();
                    end
                end
                frame_ch.valid <= next_valid;
            end
        end
    end

    // Configuration copy follows every accepted config beat; unknown indexes
    // are ignored, as the block ignores them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode <= ahdq_pkg::MODE_STEREO16;
            cur_gain <= ahdq_pkg::GAIN_RESET;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.data.index)
                ahdq_pkg::CFG_OUTPUT_MODE:
                    cur_mode <= ahdq_pkg::t_mode'(cfg_ch.data.data[0]);
                ahdq_pkg::CFG_GAIN:
                    cur_gain <= cfg_ch.data.data;
                default: ;
            endcase
        end
    end

    // Result monitor: checks each accepted result beat against the oldest
    // prediction and stalls the block in random bursts.
    always @(posedge i_clk) begin
        ahdq_pkg::t_result want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (expected_decim.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("%0t: result beat with nothing expected: L %0d R %0d M %0d",
                                 $realtime, res_ch.data.left_out, res_ch.data.right_out,
                                 res_ch.data.mono_out);
                end else begin
                    want = expected_decim.pop_front();
                    if (res_ch.data.left_out !== want.left_out ||
                        res_ch.data.right_out !== want.right_out ||
                        res_ch.data.mono_out !== want.mono_out) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"%0t: mismatch: expected L %0d R %0d M %0d,",
                                      " got L %0d R %0d M %0d"},
                                     $realtime, want.left_out, want.right_out,
                                     want.mono_out, res_ch.data.left_out,
                                     res_ch.data.right_out, res_ch.data.mono_out);
                    end
                end
            end
            if (snk_gap != 0) begin
                snk_gap <= snk_gap - 1;
                res_ch.ready <= 1'b0;
            end else if (snk_idle_pct != 0 && $urandom_range(1, 100) <= snk_idle_pct) begin
                snk_gap <= $urandom_range(0, 6);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_frame(input logic signed [ahdq_pkg::SAMPLE_W-1:0] l,
                               input logic signed [ahdq_pkg::SAMPLE_W-1:0] r);
        ahdq_pkg::t_frame f;
        f.left_sample  = l;
        f.right_sample = r;
        frame_q.push_back(f);
    endtask

    // One config beat; valid is raised at one edge and held until ready.
    task automatic write_reg(input logic [ahdq_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [ahdq_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Holds the sender back until every queued frame is taken and every
    // predicted result has come. The check runs on the falling edge, once the
    // driver's queue and valid agree. An even frame gives no result, so the task
    // then waits out SETTLE_CYCLES to let it settle before the next config write.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (frame_q.size() != 0 || frame_ch.valid || expected_decim.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [ahdq_pkg::SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1:       return 16'($urandom_range(0, 64) - 32);
            2:       return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [ahdq_pkg::GAIN_W-1:0] rand_gain();
        case ($urandom_range(0, 5))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic int rand_idle_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    initial begin
        int sent;
        int n;
        frame_ch.valid = 1'b0;
        frame_ch.data  = '0;
        res_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        i_rst_n        = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Reset configuration first: stereo mode, the mono field
        // must read zero, and full-scale extremes must pass the filter unharmed.
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sh8000, 16'sh8000);
        queue_frame(16'sh8000, 16'sh8000);
        queue_frame(16'sh7FFF, 16'sh8000);
        queue_frame(-16'sd1, 16'sd0);
        queue_frame(16'sd1, -16'sd1);
        wait_drained();

        // Mono mode at the reset gain, entered with an even frame still held.
        // The stereo fields keep carrying the decimated pair here.
        write_reg(ahdq_pkg::CFG_OUTPUT_MODE, 8'(ahdq_pkg::MODE_MONO8));
        queue_frame(16'sh8000, 16'sh7FFF);
        queue_frame(16'sd0, 16'sd0);
        queue_frame(-16'sd1, -16'sd1);
        queue_frame(16'sd3, 16'sd5);
        queue_frame(16'sd200, 16'sd100);
        wait_drained();

        // Largest gain drives the mono sum past both clip limits while the
        // unclipped error keeps feeding back.
        write_reg(ahdq_pkg::CFG_GAIN, 8'd255);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sh8000, 16'sh8000);
        queue_frame(16'sh8000, 16'sh8000);
        wait_drained();

        // Gain zero scales to nothing, so only the dither error remains; then
        // the smallest nonzero gain. A write to no register must change nothing.
        write_reg(ahdq_pkg::CFG_GAIN, 8'd0);
        write_reg(CFG_NO_REG, 8'hFF);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        wait_drained();
        write_reg(ahdq_pkg::CFG_GAIN, 8'd1);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sh7FFF, 16'sh7FFF);
        queue_frame(16'sd300, -16'sd299);
        wait_drained();

        // Random part: phases of random length and configuration, each drained
        // before the next config write. Odd lengths carry a half pair across.
        sent = 0;
        while (sent < RANDOM_ITEMS - QUIET_ITEMS) begin
            write_reg(ahdq_pkg::CFG_OUTPUT_MODE,
                      ($urandom_range(0, 2) != 0) ? 8'(ahdq_pkg::MODE_MONO8)
                                                  : 8'(ahdq_pkg::MODE_STEREO16));
            if ($urandom_range(0, 1))
                write_reg(ahdq_pkg::CFG_GAIN, rand_gain());
            src_idle_pct = rand_idle_pct();
            snk_idle_pct = rand_idle_pct();
            n = $urandom_range(40, 160);
            if (n > RANDOM_ITEMS - QUIET_ITEMS - sent)
                n = RANDOM_ITEMS - QUIET_ITEMS - sent;
            repeat (n) queue_frame(rand_sample(), rand_sample());
            sent += n;
            wait_drained();
        end

        // Last stretch runs in mono mode without any idling on either side.
        write_reg(ahdq_pkg::CFG_OUTPUT_MODE, 8'(ahdq_pkg::MODE_MONO8));
        write_reg(ahdq_pkg::CFG_GAIN, rand_gain());
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (QUIET_ITEMS) queue_frame(rand_sample(), rand_sample());
        wait_drained();

        if (mismatch_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
